>>> rtl/xbr_pkg.sv
// Shared types and constants for the xoshiro256** bounded random block.
// Holds the controller state type, request mode codes, register indexes
// and the draw masks. No dependencies.
package xbr_pkg;

    localparam int WORD_W  = 64;
    localparam int BOUND_W = 63;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int BITS_W    = 7;

    localparam logic [MODE_W-1:0] MODE_WORD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BIT      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BOUND31  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BOUND63  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESEED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_3 = 8'd3;

    localparam logic [WORD_W-1:0] SEED_0_RST = 64'd1;
    localparam logic [WORD_W-1:0] SEED_N_RST = 64'd0;

    localparam logic [WORD_W-1:0] MASK31 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [WORD_W-1:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [BITS_W-1:0] BUF_FULL  = BITS_W'(WORD_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL5,
        S_MUL9,
        S_DIV,
        S_SUB,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

>>> rtl/xoshiro256ss_bounded_random_top.sv
// Top level of the xoshiro256** bounded random block.
// Generator, bit buffer, serial divider, controller and output register.
// Depends on xbr_pkg.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries i_mode and i_bound;
//   each request gives one result on the result channel (o_out_valid /
//   i_out_ready) as o_value and o_error. Seed registers are written over the
//   cfg channel (i_cfg_valid / o_cfg_ready, always ready); the user must do
//   so only while no request is in flight, which the block does not enforce;
//   indexes above 3 are ignored.
// Sequence (request accept to result valid): word, and bit with an empty
//   buffer: S_MUL5, S_MUL9, S_OUT; bit from the buffer, reseed, error and
//   unused modes: straight to S_OUT. Bounded draws: S_MUL5, S_MUL9,
//   S_DIV, S_SUB, S_CHECK, S_OUT, a rejected draw going back to S_MUL5.
//   The divider retires one quotient bit per cycle over 64 steps.
//   One request is worked at a time; the next is taken once the previous
//   result has moved into the output register, while that result waits.
// Reset loads the seed reset values (1, 0, 0, 0) into both the seed
//   registers and the generator state and empties the bit buffer.
// A stalled receiver holds the result in the output register; a finished
//   request then waits for it, and the request channel stays not ready.
module xoshiro256ss_bounded_random_top
    import xbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [BOUND_W-1:0]   i_bound,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_value,
    output logic                 o_error,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_state r_state, n_state;

    logic [WORD_W-1:0]  r_seed0, r_seed1, r_seed2, r_seed3;
    logic [WORD_W-1:0]  r_s0, r_s1, r_s2, r_s3;
    logic [WORD_W-1:0]  r_buf;
    logic [BITS_W-1:0]  r_bits_left;

    logic [MODE_W-1:0]  r_mode;
    logic [BOUND_W-1:0] r_lim;
    logic [WORD_W-1:0]  r_limit;
    logic [WORD_W-1:0]  r_prod;
    logic [WORD_W-1:0]  r_x;
    logic [WORD_W-1:0]  r_dvd;
    logic [WORD_W-1:0]  r_rem;
    logic [WORD_W-1:0]  r_diff;
    logic [CNT_W-1:0]   r_cnt;
    logic [WORD_W-1:0]  r_res;
    logic               r_err;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_value;
    logic               r_error;

    logic               in_accept;
    logic               out_load;
    logic               bad_bound;
    logic [WORD_W-1:0]  w_mul5;
    logic [WORD_W-1:0]  w_rot;
    logic [WORD_W-1:0]  w_mul9;
    logic [WORD_W-1:0]  w_sh;
    logic               w_ge;
    logic [WORD_W-1:0]  w_rem_n;
    logic [WORD_W-1:0]  w_mask;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_error     = r_error;

    // zero bound, or a bound past 31 bits for the short draw
    always_comb begin
        bad_bound = (i_bound == '0);
        if (i_mode == MODE_BOUND31 && i_bound[BOUND_W-1:31] != '0) begin
            bad_bound = 1'b1;
        end
    end

    assign w_mask = (i_mode == MODE_BOUND31) ? MASK31 : MASK63;

    // output scrambler: s1 * 5, rotate by 7, times 9, as shift-adds
    assign w_mul5 = r_s1 + {r_s1[WORD_W-3:0], 2'b00};
    assign w_rot  = {r_prod[WORD_W-8:0], r_prod[WORD_W-1:WORD_W-7]};
    assign w_mul9 = w_rot + {w_rot[WORD_W-4:0], 3'b000};

    // restoring division step: one quotient bit per cycle
    assign w_sh    = {r_rem[WORD_W-2:0], r_dvd[WORD_W-1]};
    assign w_ge    = (w_sh >= {1'b0, r_lim});
    assign w_rem_n = w_ge ? (w_sh - {1'b0, r_lim}) : w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_mode)
                        MODE_WORD: n_state = S_MUL5;
                        MODE_BIT: begin
                            n_state = (r_bits_left == '0) ? S_MUL5 : S_OUT;
                        end
                        MODE_BOUND31, MODE_BOUND63: begin
                            n_state = bad_bound ? S_OUT : S_MUL5;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MUL5: n_state = S_MUL9;
            S_MUL9: begin
                if (r_mode == MODE_BOUND31 || r_mode == MODE_BOUND63) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SUB;
                end
            end
            S_SUB:   n_state = S_CHECK;
            S_CHECK: n_state = (r_diff <= r_limit) ? S_OUT : S_MUL5;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // seed registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed0 <= SEED_0_RST;
            r_seed1 <= SEED_N_RST;
            r_seed2 <= SEED_N_RST;
            r_seed3 <= SEED_N_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SEED_0: r_seed0 <= i_cfg_data;
                REG_SEED_1: r_seed1 <= i_cfg_data;
                REG_SEED_2: r_seed2 <= i_cfg_data;
                REG_SEED_3: r_seed3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // generator state and bit buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0        <= SEED_0_RST;
            r_s1        <= SEED_N_RST;
            r_s2        <= SEED_N_RST;
            r_s3        <= SEED_N_RST;
            r_buf       <= '0;
            r_bits_left <= '0;
        end else begin
            if (in_accept && i_mode == MODE_RESEED) begin
                r_s0        <= r_seed0;
                r_s1        <= r_seed1;
                r_s2        <= r_seed2;
                r_s3        <= r_seed3;
                r_buf       <= '0;
                r_bits_left <= '0;
            end else if (in_accept && i_mode == MODE_BIT && r_bits_left != '0) begin
                r_buf       <= {1'b0, r_buf[WORD_W-1:1]};
                r_bits_left <= r_bits_left - 1'b1;
            end else if (r_state == S_MUL5) begin
                r_s0 <= r_s0 ^ r_s3 ^ r_s1;
                r_s1 <= r_s1 ^ r_s2 ^ r_s0;
                r_s2 <= r_s2 ^ r_s0 ^ {r_s1[WORD_W-18:0], 17'd0};
                r_s3 <= {r_s3[18:0] ^ r_s1[18:0], r_s3[WORD_W-1:19] ^ r_s1[WORD_W-1:19]};
            end else if (r_state == S_MUL9 && r_mode == MODE_BIT) begin
                // refill: the low bit goes out now, 63 stay
                r_buf       <= {1'b0, w_mul9[WORD_W-1:1]};
                r_bits_left <= BUF_FULL - 1'b1;
            end
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_mode  <= i_mode;
                    r_lim   <= i_bound;
                    r_limit <= w_mask - {1'b0, i_bound} + 1'b1;
                    if (i_mode == MODE_BIT) begin
                        r_res <= {{(WORD_W-1){1'b0}}, r_buf[0]};
                    end else begin
                        r_res <= '0;
                    end
                    r_err <= (i_mode inside {MODE_BOUND31, MODE_BOUND63}) && bad_bound;
                end
            end
            S_MUL5: r_prod <= w_mul5;
            S_MUL9: begin
                if (r_mode == MODE_BIT) begin
                    r_res <= {{(WORD_W-1){1'b0}}, w_mul9[0]};
                end else begin
                    r_res <= w_mul9;
                end
                if (r_mode == MODE_BOUND31) begin
                    r_x   <= w_mul9 & MASK31;
                    r_dvd <= w_mul9 & MASK31;
                end else begin
                    r_x   <= w_mul9 & MASK63;
                    r_dvd <= w_mul9 & MASK63;
                end
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_rem_n;
                r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            S_SUB: r_diff <= r_x - r_rem;
            S_CHECK: r_res <= r_rem;
            default: ;
        endcase
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_value <= r_res;
            r_error <= r_err;
        end
    end

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error) |-> (r_value == '0))
        else $error("error result with nonzero value");

    a_rem_below_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_lim}))
        else $error("divider remainder not below bound");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= BUF_FULL)
        else $error("bit buffer count out of range");

    a_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_mode == MODE_RESEED) |=>
            (r_s0 == $past(r_seed0) && r_s3 == $past(r_seed3) && r_bits_left == '0))
        else $error("reseed did not load generator state");
`endif

endmodule
